/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define RSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true out of reset
`define RSC_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define RSC_ASSERT(lbl, prop)
`define RSC_ASSERT_NEVER(lbl, expr)

`endif

`endif

/* src/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// rsc_pkg
// shared widths, codes and structs of the sensor resistance classifier
// ----------------------------------------------------------------------------
package rsc_pkg;

    // field widths
    localparam int CHAN_W     = 3;
    localparam int SAMPLE_W   = 10;
    localparam int SUM_W      = 13;
    localparam int CNT_W      = 3;
    localparam int RATIO_W    = 16;
    localparam int CLASS_W    = 3;
    localparam int ENABLE_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // ratio divider widths: avg*1000 fits 20 bits, 1024-avg fits 11 bits
    localparam int DIVIDEND_W = 20;
    localparam int DIVISOR_W  = 11;

    // class codes
    localparam logic [CLASS_W-1:0] CLASS_NORMAL = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_LOW    = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_HIGH   = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_OPEN   = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_SHORT  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_UPPER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LOWER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LOWER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT    = 3'd4;

    // register reset values
    localparam logic [RATIO_W-1:0] NORMAL_UPPER_RST = 16'd1680;
    localparam logic [RATIO_W-1:0] NORMAL_LOWER_RST = 16'd1220;
    localparam logic [RATIO_W-1:0] HIGH_LOWER_RST   = 16'd750;
    localparam logic [RATIO_W-1:0] SHORT_LIMIT_RST  = 16'd480;

    // finished reading from the accumulator
    typedef struct packed {
        logic              complete;
        logic [CHAN_W-1:0] chan;
        logic [SUM_W-1:0]  sum;
    } acc_reading_t;

    // serial divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* src/sensor_resistance_classifier_top.sv */
// ----------------------------------------------------------------------------
// sensor_resistance_classifier_top
// averages samples per channel, derives the resistance ratio and its band
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   input    | in_valid, in_ready, chan, sample               | in
//   result   | out_valid, out_ready, chan_out, average,       | out
//            | ratio, sensor_class                            |
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// a sample that does not finish a reading leaves input ready for the next sample
// a finishing sample reaches the result register through the average multiply,
//   divider start, 20-step bit-serial ratio divider, done and result load; the
//   load waits for a free result register; input is ready in the next cycle
// input is taken only while no reading is in work; a held result does not
//   block input until the next reading needs the result register
// reset clears all channel sums and counts at once, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_resistance_classifier_top #(
    parameter int SAMPLES_PER_READING = 5,
    parameter int CHANNELS            = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rsc_pkg::CHAN_W-1:0]        chan,
    input  logic [rsc_pkg::SAMPLE_W-1:0]      sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rsc_pkg::CHAN_W-1:0]        chan_out,
    output logic [rsc_pkg::SAMPLE_W-1:0]      average,
    output logic [rsc_pkg::RATIO_W-1:0]       ratio,
    output logic [rsc_pkg::CLASS_W-1:0]       sensor_class,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // average = sum * ceil(2^17 / n) >> 17, exact for sums below 8192
    localparam int AVG_SHIFT = 17;
    localparam int MULT_W    = AVG_SHIFT + 1;
    localparam int PROD_W    = rsc_pkg::SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] AVG_MULT =
        MULT_W'(((2 ** AVG_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;

    logic [rsc_pkg::ENABLE_W-1:0]    channel_enable_reg;
    logic [rsc_pkg::RATIO_W-1:0]     normal_upper_reg;
    logic [rsc_pkg::RATIO_W-1:0]     normal_lower_reg;
    logic [rsc_pkg::RATIO_W-1:0]     high_lower_reg;
    logic [rsc_pkg::RATIO_W-1:0]     short_limit_reg;

    logic [PROD_W-1:0]               prod_reg;
    logic [rsc_pkg::SAMPLE_W-1:0]    avg_reg;

    logic                            out_valid_reg;
    logic [rsc_pkg::CHAN_W-1:0]      chan_out_reg;
    logic [rsc_pkg::SAMPLE_W-1:0]    average_reg;
    logic [rsc_pkg::RATIO_W-1:0]     ratio_reg;
    logic [rsc_pkg::CLASS_W-1:0]     sensor_class_reg;

    rsc_pkg::acc_reading_t           reading;
    rsc_pkg::div_status_t            div_stat;
    logic [rsc_pkg::DIVIDEND_W-1:0]  quotient;

    logic                            in_xfer;
    logic                            out_free;
    logic                            div_start;
    logic [rsc_pkg::SAMPLE_W-1:0]    avg_calc;
    logic [rsc_pkg::DIVIDEND_W-1:0]  dividend;
    logic [rsc_pkg::DIVISOR_W-1:0]   divisor;
    logic [rsc_pkg::RATIO_W-1:0]     ratio_sat;
    logic [rsc_pkg::CLASS_W-1:0]     class_calc;

    // handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign div_start = (state_reg == S_START);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_enable_reg <= '0;
            normal_upper_reg   <= rsc_pkg::NORMAL_UPPER_RST;
            normal_lower_reg   <= rsc_pkg::NORMAL_LOWER_RST;
            high_lower_reg     <= rsc_pkg::HIGH_LOWER_RST;
            short_limit_reg    <= rsc_pkg::SHORT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rsc_pkg::REG_CHANNEL_ENABLE: channel_enable_reg <= cfg_data[rsc_pkg::ENABLE_W-1:0];
                rsc_pkg::REG_NORMAL_UPPER:   normal_upper_reg   <= cfg_data;
                rsc_pkg::REG_NORMAL_LOWER:   normal_lower_reg   <= cfg_data;
                rsc_pkg::REG_HIGH_LOWER:     high_lower_reg     <= cfg_data;
                rsc_pkg::REG_SHORT_LIMIT:    short_limit_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-channel accumulation
    rsc_accum #(
        .CHANNELS            (CHANNELS),
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_xfer),
        .chan           (chan),
        .sample         (sample),
        .channel_enable (channel_enable_reg),
        .reading        (reading)
    );

    // divider operands: avg*1000 = avg*1024 - avg*16 - avg*8
    always_comb
    begin
        avg_calc = prod_reg[AVG_SHIFT +: rsc_pkg::SAMPLE_W];
        dividend = (rsc_pkg::DIVIDEND_W'(avg_calc) << 10)
                 - (rsc_pkg::DIVIDEND_W'(avg_calc) << 4)
                 - (rsc_pkg::DIVIDEND_W'(avg_calc) << 3);
        divisor  = rsc_pkg::DIVISOR_W'(1024) - rsc_pkg::DIVISOR_W'(avg_calc);
    end

    rsc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_stat)
    );

    // saturation and band selection, first matching band wins
    always_comb
    begin
        ratio_sat = (|quotient[rsc_pkg::DIVIDEND_W-1:rsc_pkg::RATIO_W]) ?
                    '1 : quotient[rsc_pkg::RATIO_W-1:0];
        if (ratio_sat > normal_lower_reg && ratio_sat <= normal_upper_reg)
            class_calc = rsc_pkg::CLASS_NORMAL;
        else if (ratio_sat >= high_lower_reg && ratio_sat <= normal_lower_reg)
            class_calc = rsc_pkg::CLASS_HIGH;
        else if (ratio_sat > short_limit_reg && ratio_sat <= high_lower_reg)
            class_calc = rsc_pkg::CLASS_LOW;
        else if (ratio_sat <= short_limit_reg)
            class_calc = rsc_pkg::CLASS_SHORT;
        else
            class_calc = rsc_pkg::CLASS_OPEN;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (reading.complete) state_next = S_MUL;
            S_MUL:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:   if (div_stat.done) state_next = S_EMIT;
            S_EMIT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // average multiply and capture
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
            prod_reg <= PROD_W'(reading.sum) * PROD_W'(AVG_MULT);
        if (div_start)
            avg_reg <= avg_calc;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_EMIT && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && out_free)
        begin
            chan_out_reg     <= reading.chan;
            average_reg      <= avg_reg;
            ratio_reg        <= ratio_sat;
            sensor_class_reg <= class_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chan_out     = chan_out_reg;
    assign average      = average_reg;
    assign ratio        = ratio_reg;
    assign sensor_class = sensor_class_reg;

    // checks
    `RSC_ASSERT(a_done_in_div, div_stat.done |-> state_reg == S_DIV)
    `RSC_ASSERT(a_emit_holds, state_reg == S_EMIT && out_valid_reg && !out_ready |=> state_reg == S_EMIT)
    `RSC_ASSERT(a_class_range, out_valid_reg |-> sensor_class_reg <= rsc_pkg::CLASS_SHORT)

endmodule

/* src/rsc_accum.sv */
// ----------------------------------------------------------------------------
// rsc_accum
// per-channel sample sum and count, reports a channel's sum when full
// ----------------------------------------------------------------------------
module rsc_accum #(
    parameter int CHANNELS            = 8,
    parameter int SAMPLES_PER_READING = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [rsc_pkg::CHAN_W-1:0]      chan,
    input  logic [rsc_pkg::SAMPLE_W-1:0]    sample,
    input  logic [rsc_pkg::ENABLE_W-1:0]    channel_enable,
    output rsc_pkg::acc_reading_t           reading
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [rsc_pkg::CNT_W:0]  SPR_L = (rsc_pkg::CNT_W + 1)'(SAMPLES_PER_READING);
    localparam logic [rsc_pkg::CHAN_W:0] CH_L  = (rsc_pkg::CHAN_W + 1)'(CHANNELS);

    logic [rsc_pkg::SUM_W-1:0]  sum_reg [CHANNELS];
    logic [rsc_pkg::CNT_W-1:0]  cnt_reg [CHANNELS];
    logic [rsc_pkg::SUM_W-1:0]  sum_out_reg;
    logic [rsc_pkg::CHAN_W-1:0] chan_out_reg;

    logic [IDX_W-1:0]           idx;
    logic                       hit;
    logic [rsc_pkg::SUM_W-1:0]  sum_next;
    logic [rsc_pkg::CNT_W:0]    cnt_next;
    logic                       complete;

    // channel lookup and update values
    always_comb
    begin
        idx      = chan[IDX_W-1:0];
        hit      = accept && ({1'b0, chan} < CH_L) && channel_enable[chan];
        sum_next = sum_reg[idx] + rsc_pkg::SUM_W'(sample);
        cnt_next = {1'b0, cnt_reg[idx]} + 1'b1;
        complete = hit && (cnt_next >= SPR_L);
    end

    // per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (hit)
        begin
            if (complete)
            begin
                sum_reg[idx] <= '0;
                cnt_reg[idx] <= '0;
            end
            else
            begin
                sum_reg[idx] <= sum_next;
                cnt_reg[idx] <= cnt_next[rsc_pkg::CNT_W-1:0];
            end
        end
    end

    // finished sum held for the ratio stage
    always_ff @(posedge clk)
    begin
        if (complete)
        begin
            sum_out_reg  <= sum_next;
            chan_out_reg <= chan;
        end
    end

    assign reading.complete = complete;
    assign reading.chan     = chan_out_reg;
    assign reading.sum      = sum_out_reg;

endmodule

/* src/rsc_divider.sv */
// ----------------------------------------------------------------------------
// rsc_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsc_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [rsc_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [rsc_pkg::DIVISOR_W-1:0]    divisor,
    output logic [rsc_pkg::DIVIDEND_W-1:0]   quotient,
    output rsc_pkg::div_status_t             status
);

    localparam int STEPS  = rsc_pkg::DIVIDEND_W;
    localparam int STEP_W = $clog2(STEPS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    logic [rsc_pkg::DIVIDEND_W-1:0] quo_reg;
    logic [rsc_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [rsc_pkg::DIVISOR_W-1:0]  divisor_reg;
    logic [STEP_W-1:0]              step_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [rsc_pkg::DIVISOR_W:0]    trial;
    logic [rsc_pkg::DIVISOR_W:0]    diff;
    logic                           fits;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[rsc_pkg::DIVIDEND_W-1]};
        fits  = trial >= {1'b0, divisor_reg};
        diff  = trial - {1'b0, divisor_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[rsc_pkg::DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[rsc_pkg::DIVISOR_W-1:0] : trial[rsc_pkg::DIVISOR_W-1:0];
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    // checks
    `RSC_ASSERT(a_start_busy, start |=> busy_reg)
    `RSC_ASSERT_NEVER(a_busy_done, busy_reg && done_reg)
    `RSC_ASSERT(a_step_bound, busy_reg |-> step_reg <= LAST_STEP)

endmodule
